[hw/rtl/u8d_pkg.sv]
// Package for the UTF-8 stream decoder: byte classes, queue entry and
// result status types. No dependencies.

package u8d_pkg;

  // Sequence length codes carried by a classified byte
  localparam logic [2:0] LEN_INVALID = 3'd0;
  localparam logic [2:0] LEN_ONE     = 3'd1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LEAD = 2'd1,
    ST_BAD_CONT = 2'd2,
    ST_TRUNC    = 2'd3
  } status_t;

  // One classified byte as it sits in the queue
  typedef struct packed {
    logic [7:0] data;      // raw byte, low six bits are continuation payload
    logic [6:0] lead_val;  // lead payload under the mask for its length
    logic [2:0] lead_len;  // sequence length if taken as lead, LEN_INVALID if not
    logic       is_cont;   // byte matches 10xxxxxx
    logic       eod;       // end-of-data mark
  } item_t;

  // Queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic avail;
  } q_stat_t;

endpackage

[hw/rtl/u8d_ifs.sv]
// Valid/ready channel interfaces for the UTF-8 stream decoder:
// the byte input channel and the character result channel. No dependencies.

interface u8d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_data;

  modport source (output valid, output in_byte, output end_of_data, input ready);
  modport sink   (input valid, input in_byte, input end_of_data, output ready);
endinterface

interface u8d_char_if;
  logic        valid;
  logic        ready;
  logic [30:0] code_point;
  logic [2:0]  seq_length;
  logic [1:0]  status;

  modport source (output valid, output code_point, output seq_length, output status,
                  input ready);
  modport sink   (input valid, input code_point, input seq_length, input status,
                  output ready);
endinterface

[hw/rtl/u8d_front.sv]
// Front end of the UTF-8 decoder: accepts input words and classifies each byte.
// Depends on u8d_pkg and u8d_byte_if.

module u8d_front (
  u8d_byte_if.sink         bytes,
  input  u8d_pkg::q_stat_t q_stat,
  output logic             push,
  output u8d_pkg::item_t   item
);

  logic [7:0] b;

  assign b = bytes.in_byte;

  // Accept whenever the queue has room
  assign bytes.ready = !q_stat.full;
  assign push        = bytes.valid && !q_stat.full;

  // Classify the byte as lead and as continuation
  always_comb begin
    item.data     = b;
    item.eod      = bytes.end_of_data;
    item.is_cont  = (b[7:6] == 2'b10);
    item.lead_len = u8d_pkg::LEN_INVALID;
    item.lead_val = 7'd0;
    case (b) inside
      [8'h00:8'h7F]: begin
        item.lead_len = u8d_pkg::LEN_ONE;
        item.lead_val = b[6:0];
      end
      [8'hC0:8'hDF]: begin
        item.lead_len = 3'd2;
        item.lead_val = {2'b00, b[4:0]};
      end
      [8'hE0:8'hEF]: begin
        item.lead_len = 3'd3;
        item.lead_val = {3'b000, b[3:0]};
      end
      [8'hF0:8'hF7]: begin
        item.lead_len = 3'd4;
        item.lead_val = {4'b0000, b[2:0]};
      end
      [8'hF8:8'hFB]: begin
        item.lead_len = 3'd5;
        item.lead_val = {5'b00000, b[1:0]};
      end
      [8'hFC:8'hFD]: begin
        item.lead_len = 3'd6;
        item.lead_val = {6'b000000, b[0]};
      end
      default: begin
        item.lead_len = u8d_pkg::LEN_INVALID;
        item.lead_val = 7'd0;
      end
    endcase
  end

endmodule

[hw/rtl/u8d_fifo.sv]
// Short queue of classified bytes between the decoder front and back.
// Depends on u8d_pkg.

module u8d_fifo #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  u8d_pkg::item_t   wr_item,
  input  logic             pop,
  output u8d_pkg::item_t   rd_item,
  output u8d_pkg::q_stat_t q_stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  u8d_pkg::item_t entries [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign q_stat.full  = (count == FULL_COUNT);
  assign q_stat.avail = (count != '0);
  assign rd_item      = entries[rd_ptr];

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_item;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && q_stat.full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !q_stat.avail))
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("queue count beyond depth");

endmodule

[hw/rtl/u8d_back.sv]
// Back end of the UTF-8 decoder: runs the sequence state and drives the
// registered result channel. Depends on u8d_pkg and u8d_char_if.

module u8d_back (
  input  logic             clk,
  input  logic             rst,
  input  u8d_pkg::q_stat_t q_stat,
  input  u8d_pkg::item_t   item,
  output logic             pop,
  u8d_char_if.source       chars
);

  logic [30:0] partial;
  logic [2:0]  remaining;
  logic [2:0]  total;
  logic [30:0] partial_next;
  logic [2:0]  remaining_next;
  logic [2:0]  total_next;

  logic        out_valid;
  logic [30:0] out_cp;
  logic [2:0]  out_len;
  u8d_pkg::status_t out_status;

  logic        emit;
  logic [30:0] res_cp;
  logic [2:0]  res_len;
  u8d_pkg::status_t res_status;
  logic [30:0] acc;

  // Take the next word when the result register is free or draining
  assign pop = q_stat.avail && (!out_valid || chars.ready);
  assign acc = {partial[24:0], item.data[5:0]};

  // Decode step
  always_comb begin
    partial_next   = partial;
    remaining_next = remaining;
    total_next     = total;
    emit           = 1'b0;
    res_cp         = 31'd0;
    res_len        = 3'd0;
    res_status     = u8d_pkg::ST_OK;
    if (pop) begin
      if (remaining == 3'd0) begin
        if (item.lead_len == u8d_pkg::LEN_INVALID) begin
          emit       = 1'b1;
          res_status = u8d_pkg::ST_BAD_LEAD;
        end else if (item.lead_len == u8d_pkg::LEN_ONE) begin
          emit    = 1'b1;
          res_cp  = {24'd0, item.lead_val};
          res_len = u8d_pkg::LEN_ONE;
        end else if (item.eod) begin
          emit       = 1'b1;
          res_status = u8d_pkg::ST_TRUNC;
        end else begin
          partial_next   = {24'd0, item.lead_val};
          total_next     = item.lead_len;
          remaining_next = item.lead_len - 3'd1;
        end
      end else if (!item.is_cont) begin
        // drop the partial sequence and the offending byte
        emit           = 1'b1;
        res_status     = u8d_pkg::ST_BAD_CONT;
        partial_next   = 31'd0;
        remaining_next = 3'd0;
        total_next     = 3'd0;
      end else if (remaining == 3'd1) begin
        emit           = 1'b1;
        res_cp         = acc;
        res_len        = total;
        partial_next   = 31'd0;
        remaining_next = 3'd0;
        total_next     = 3'd0;
      end else if (item.eod) begin
        emit           = 1'b1;
        res_status     = u8d_pkg::ST_TRUNC;
        partial_next   = 31'd0;
        remaining_next = 3'd0;
        total_next     = 3'd0;
      end else begin
        partial_next   = acc;
        remaining_next = remaining - 3'd1;
      end
    end
  end

  // Hold sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      partial   <= 31'd0;
      remaining <= 3'd0;
      total     <= 3'd0;
    end else begin
      partial   <= partial_next;
      remaining <= remaining_next;
      total     <= total_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (chars.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_cp     <= res_cp;
      out_len    <= res_len;
      out_status <= res_status;
    end
  end

  assign chars.valid      = out_valid;
  assign chars.code_point = out_cp;
  assign chars.seq_length = out_len;
  assign chars.status     = out_status;

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    remaining <= 3'd5)
    else $error("continuation count beyond five");

  a_total_set: assert property (@(posedge clk) disable iff (rst)
    (remaining != 3'd0) |-> (total >= 3'd2 && total == remaining + 3'd1 ||
                             total > remaining + 3'd1))
    else $error("sequence length inconsistent with pending count");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != u8d_pkg::ST_OK) |-> (out_cp == 31'd0 && out_len == 3'd0))
    else $error("error result carries a value");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    emit |=> out_valid)
    else $error("result lost");

endmodule

[hw/rtl/utf8_stream_decoder_top.sv]
// UTF-8 stream decoder (six-byte form), top level.
// Depends on u8d_pkg, u8d_ifs, u8d_front, u8d_fifo and u8d_back.
//
// Usage:
//   bytes : one raw stream byte per word, with end_of_data on the last one.
//   chars : one decoded character or error per word: code_point, seq_length
//           and status (ok, invalid lead, bad continuation, truncated).
//   A word is taken on a clock edge where valid and ready are both high.
//   Path: a taken byte is first registered in the queue, then passes the
//   combinational decode step into the result register, which drives chars.
//   Throughput: one byte per clock while chars does not stall; bytes inside a
//   sequence give no result.
//   The input is ready while the DEPTH-entry queue has room; when chars stalls,
//   the back end holds its result register and the queue absorbs up to DEPTH
//   further bytes before ready drops.
//   Reset (rst, synchronous) empties the queue, clears any partial sequence
//   and drops a pending result.

module utf8_stream_decoder_top #(
  parameter int DEPTH = 4
) (
  input logic        clk,
  input logic        rst,
  u8d_byte_if.sink   bytes,
  u8d_char_if.source chars
);

  u8d_pkg::q_stat_t q_stat;
  u8d_pkg::item_t   wr_item;
  u8d_pkg::item_t   rd_item;
  logic             push;
  logic             pop;

  u8d_front u_front (
    .bytes  (bytes),
    .q_stat (q_stat),
    .push   (push),
    .item   (wr_item)
  );

  u8d_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (wr_item),
    .pop     (pop),
    .rd_item (rd_item),
    .q_stat  (q_stat)
  );

  u8d_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_stat (q_stat),
    .item   (rd_item),
    .pop    (pop),
    .chars  (chars)
  );

endmodule

[test/utf8_stream_decoder_top_test.sv]
`timescale 1ns / 100ps
// Self-checking bench for utf8_stream_decoder_top: drives bytes through valid/ready
// and predicts each decoded character. Depends on u8d_pkg, u8d_ifs and the decoder RTL.

module utf8_stream_decoder_top_test;

  localparam int IDLE_LIMIT   = 2000;
  localparam int PHASE_BYTES  = 140;
  localparam int REPORT_LIMIT = 40;

  typedef enum int {
    PACE_STEADY,
    PACE_SENDER_GAPS,
    PACE_RECEIVER_STALLS,
    PACE_BOTH
  } pace_t;

  typedef struct {
    logic [7:0] data;
    logic       eod;
  } byte_word_t;

  typedef struct {
    logic [30:0]      code_point;
    logic [2:0]       seq_length;
    u8d_pkg::status_t status;
  } char_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  pace_t pace = PACE_STEADY;

  byte_word_t pending_bytes[$];
  char_word_t expected_chars[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int bytes_queued = 0;

  // Decoder state held by the predictor
  logic [30:0] gathered_bits = '0;
  logic [2:0]  cont_left = '0;
  logic [2:0]  seq_total = '0;

  u8d_byte_if bytes_if ();
  u8d_char_if chars_if ();

  utf8_stream_decoder_top u_dut (
    .clk   (clk),
    .rst   (rst),
    .bytes (bytes_if),
    .chars (chars_if)
  );

  always #5 clk = ~clk;

  function automatic void drop_sequence();
    gathered_bits = '0;
    cont_left     = '0;
    seq_total     = '0;
  endfunction

  // Advance the decoder by one byte; return 1 when a character or error comes out
  function automatic bit decode_byte(input logic [7:0] b, input logic eod,
                                     output char_word_t res);
    logic [30:0] lead_bits;
    logic [2:0]  lead_len;
    res = '{code_point: '0, seq_length: '0, status: u8d_pkg::ST_OK};
    if (cont_left == 0) begin
      lead_bits = '0;
      lead_len  = '0;
      if (b[7] == 1'b0) begin
        res.code_point = {23'd0, b};
        res.seq_length = 3'd1;
        return 1'b1;
      end else if ((b & 8'hE0) == 8'hC0) begin
        lead_bits = 31'(b & 8'h1F);
        lead_len  = 3'd2;
      end else if ((b & 8'hF0) == 8'hE0) begin
        lead_bits = 31'(b & 8'h0F);
        lead_len  = 3'd3;
      end else if ((b & 8'hF8) == 8'hF0) begin
        lead_bits = 31'(b & 8'h07);
        lead_len  = 3'd4;
      end else if ((b & 8'hFC) == 8'hF8) begin
        lead_bits = 31'(b & 8'h03);
        lead_len  = 3'd5;
      end else if ((b & 8'hFE) == 8'hFC) begin
        lead_bits = 31'(b & 8'h01);
        lead_len  = 3'd6;
      end
      if (lead_len == 0) begin
        drop_sequence();
        res.status = u8d_pkg::ST_BAD_LEAD;
        return 1'b1;
      end
      if (eod) begin
        drop_sequence();
        res.status = u8d_pkg::ST_TRUNC;
        return 1'b1;
      end
      gathered_bits = lead_bits;
      seq_total     = lead_len;
      cont_left     = lead_len - 3'd1;
      return 1'b0;
    end
    // Inside a sequence: a non-continuation byte aborts and is dropped
    if (b[7:6] != 2'b10) begin
      drop_sequence();
      res.status = u8d_pkg::ST_BAD_CONT;
      return 1'b1;
    end
    gathered_bits = {gathered_bits[24:0], b[5:0]};
    cont_left     = cont_left - 3'd1;
    if (cont_left == 0) begin
      res.code_point = gathered_bits;
      res.seq_length = seq_total;
      drop_sequence();
      return 1'b1;
    end
    if (eod) begin
      drop_sequence();
      res.status = u8d_pkg::ST_TRUNC;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit sender_gap();
    case (pace)
      PACE_SENDER_GAPS: return $urandom_range(99) < 86;
      PACE_BOTH:        return $urandom_range(99) < 17;
      default:          return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stall();
    case (pace)
      PACE_RECEIVER_STALLS: return $urandom_range(99) < 86;
      PACE_BOTH:            return $urandom_range(99) < 17;
      default:              return 1'b0;
    endcase
  endfunction

  task automatic report_field(input string field, input logic [30:0] exp_val,
                              input logic [30:0] act_val);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field,
               exp_val, act_val);
  endtask

  task automatic add_byte(input logic [7:0] b, input logic eod);
    pending_bytes.push_back('{data: b, eod: eod});
    bytes_queued++;
  endtask

  // Queue one character sequence, mostly well formed, sometimes broken
  task automatic add_random_sequence();
    logic [7:0] seq[$];
    logic [7:0] junk;
    int len;
    int pick;
    int cut;
    int spot;
    pick = $urandom_range(99);
    len  = $urandom_range(1, 6);
    case (len)
      1: seq.push_back(8'($urandom_range(8'h00, 8'h7F)));
      2: seq.push_back(8'($urandom_range(8'hC0, 8'hDF)));
      3: seq.push_back(8'($urandom_range(8'hE0, 8'hEF)));
      4: seq.push_back(8'($urandom_range(8'hF0, 8'hF7)));
      5: seq.push_back(8'($urandom_range(8'hF8, 8'hFB)));
      default: seq.push_back(8'($urandom_range(8'hFC, 8'hFD)));
    endcase
    for (int i = 1; i < len; i++) seq.push_back(8'($urandom_range(8'h80, 8'hBF)));

    if (pick < 8) begin
      // Noise: any byte, any end mark
      add_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
    end else if (pick < 16 && len > 1) begin
      // Corrupt one continuation byte
      do junk = 8'($urandom_range(255)); while (junk[7:6] == 2'b10);
      spot = $urandom_range(1, len - 1);
      for (int i = 0; i < spot; i++) add_byte(seq[i], 1'b0);
      add_byte(junk, 1'($urandom_range(1)));
    end else if (pick < 24 && len > 1) begin
      // Cut the sequence short with the end mark
      cut = $urandom_range(1, len - 1);
      for (int i = 0; i < cut; i++) add_byte(seq[i], i == cut - 1);
    end else if (pick < 28) begin
      // Stray continuation or never-valid lead
      if ($urandom_range(3) == 0) junk = 8'($urandom_range(8'hFE, 8'hFF));
      else junk = 8'($urandom_range(8'h80, 8'hBF));
      add_byte(junk, 1'($urandom_range(1)));
    end else begin
      for (int i = 0; i < len; i++)
        add_byte(seq[i], (i == len - 1) && ($urandom_range(19) == 0));
    end
  endtask

  // Byte driver: hold a word until taken, predict on acceptance
  always @(posedge clk) begin
    char_word_t got;
    byte_word_t next_word;
    bit taken;
    if (rst) begin
      bytes_if.valid <= 1'b0;
    end else begin
      taken = bytes_if.valid && bytes_if.ready;
      if (taken) begin
        if (decode_byte(bytes_if.in_byte, bytes_if.end_of_data, got))
          expected_chars.push_back(got);
      end
      if (taken || !bytes_if.valid) begin
        if (pending_bytes.size() != 0 && !sender_gap()) begin
          next_word = pending_bytes.pop_front();
          bytes_if.valid       <= 1'b1;
          bytes_if.in_byte     <= next_word.data;
          bytes_if.end_of_data <= next_word.eod;
        end else begin
          bytes_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each word with the oldest expectation
  always @(posedge clk) begin
    char_word_t want;
    if (rst) begin
      chars_if.ready <= 1'b0;
    end else begin
      if (chars_if.valid && chars_if.ready) begin
        if (expected_chars.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word, expected none, actual cp=0x%0h len=%0d st=%0d",
                   $time, chars_if.code_point, chars_if.seq_length, chars_if.status);
        end else begin
          want = expected_chars.pop_front();
          if (chars_if.code_point !== want.code_point)
            report_field("code_point", want.code_point, chars_if.code_point);
          if (chars_if.seq_length !== want.seq_length)
            report_field("seq_length", 31'(want.seq_length), 31'(chars_if.seq_length));
          if (chars_if.status !== want.status)
            report_field("status", 31'(want.status), 31'(chars_if.status));
        end
      end
      chars_if.ready <= !receiver_stall();
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk) begin
    if (rst || (bytes_if.valid && bytes_if.ready) || (chars_if.valid && chars_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    bytes_if.valid       = 1'b0;
    bytes_if.in_byte     = 8'h00;
    bytes_if.end_of_data = 1'b0;
    chars_if.ready       = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: one-byte extremes, invalid leads, widest sequence, error paths
    add_byte(8'h00, 1'b0);
    add_byte(8'h7F, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hFE, 1'b0);
    add_byte(8'hFF, 1'b1);
    add_byte(8'hC0, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hEF, 1'b0);
    add_byte(8'hBF, 1'b0);
    add_byte(8'hBF, 1'b0);
    add_byte(8'hFD, 1'b0);
    repeat (5) add_byte(8'hBF, 1'b0);
    add_byte(8'hE2, 1'b0);
    add_byte(8'h41, 1'b0);
    add_byte(8'hE2, 1'b0);
    add_byte(8'hC1, 1'b1);
    add_byte(8'hC3, 1'b1);
    add_byte(8'hF0, 1'b0);
    add_byte(8'h90, 1'b1);
    add_byte(8'h41, 1'b1);
    while (pending_bytes.size() != 0) @(posedge clk);

    // Random traffic under each pacing mode
    for (int p = 0; p < 4; p++) begin
      pace = pace_t'(p);
      bytes_queued = 0;
      while (bytes_queued < PHASE_BYTES) add_random_sequence();
      while (pending_bytes.size() != 0) @(posedge clk);
    end

    while (pending_bytes.size() != 0 || bytes_if.valid) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
